>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file ims_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset disables
`define IMS_ASSERT_IMPLY(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("integer_membership_set: assertion failed");

// next-cycle implication, reset disables
`define IMS_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("integer_membership_set: assertion failed");

`endif

>>> design/ims_pkg.sv
// ----------------------------------------------------------------------------
// ims_pkg
// types, constants and helpers of the integer membership set
// ----------------------------------------------------------------------------
package ims_pkg;

	localparam int CAPACITY   = 256;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int COUNT_W    = 9;
	localparam int VALUE_W    = 32;
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_QUERY
	} op_t;

	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_SCAN,
		ENG_ACT,
		ENG_READ_LAST,
		ENG_WRITE_LAST,
		ENG_EMIT
	} eng_state_t;

	typedef struct packed {
		logic [1:0]                mode;
		logic signed [VALUE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic               was_present;
		logic               status;
		logic [COUNT_W-1:0] count;
	} out_item_t;

	typedef struct packed {
		op_t                op;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic vld;
		cmd_t cmd;
	} cmd_lnk_t;

	// low bits of the live count as the result field
	function automatic logic [COUNT_W-1:0] to_count_field(input logic [CNT_W-1:0] c);
		logic [CNT_W+COUNT_W-1:0] w;
		w = {{COUNT_W{1'b0}}, c};
		return w[COUNT_W-1:0];
	endfunction

endpackage

>>> design/ims_front.sv
// ----------------------------------------------------------------------------
// ims_front
// accepts input beats, decodes the mode and queues commands for the engine
// ----------------------------------------------------------------------------
module ims_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  ims_pkg::in_item_t   item,
	output ims_pkg::cmd_lnk_t   lnk,
	input  logic                take
);

	ims_pkg::cmd_t                         q_mem [ims_pkg::CMDQ_DEPTH];
	logic [ims_pkg::CMDQ_PTR_W-1:0]        wr_ptr_q;
	logic [ims_pkg::CMDQ_PTR_W-1:0]        rd_ptr_q;
	logic [ims_pkg::CMDQ_CNT_W-1:0]        fill_q;
	ims_pkg::cmd_t                         cmd_in;
	logic                                  do_push;
	logic                                  do_pop;

	always_comb begin
		case (item.mode)
			ims_pkg::MODE_INSERT: cmd_in.op = ims_pkg::OP_INSERT;
			ims_pkg::MODE_REMOVE: cmd_in.op = ims_pkg::OP_REMOVE;
			default:              cmd_in.op = ims_pkg::OP_QUERY;
		endcase
		cmd_in.value = $unsigned(item.value);
	end

	assign full    = (fill_q == ims_pkg::CMDQ_CNT_W'(ims_pkg::CMDQ_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = take && (fill_q != '0);

	assign lnk.vld = (fill_q != '0);
	assign lnk.cmd = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!do_push && do_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> design/ims_engine.sv
// ----------------------------------------------------------------------------
// ims_engine
// entry table, linear search sequencer, swap removal and result register
// ----------------------------------------------------------------------------
module ims_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  ims_pkg::cmd_lnk_t   lnk,
	output logic                take,
	output logic                empty,
	input  logic                pop,
	output ims_pkg::out_item_t  result
);

	ims_pkg::eng_state_t               state_q;
	ims_pkg::eng_state_t               state_d;

	logic [ims_pkg::VALUE_W-1:0]       mem [ims_pkg::CAPACITY];
	logic [ims_pkg::VALUE_W-1:0]       rdata_q;

	ims_pkg::op_t                      op_q;
	logic [ims_pkg::VALUE_W-1:0]       value_q;
	logic [ims_pkg::CNT_W-1:0]         cnt_q;
	logic [ims_pkg::CNT_W-1:0]         issue_idx_q;
	logic                              cmp_vld_q;
	logic [ims_pkg::IDX_W-1:0]         cmp_idx_q;
	logic                              found_q;
	logic [ims_pkg::IDX_W-1:0]         slot_q;
	logic                              refused_q;
	ims_pkg::out_item_t                out_q;
	logic                              out_vld_q;

	logic                              hit;
	logic                              miss;
	logic                              out_free;
	logic                              can_add;
	logic [ims_pkg::CNT_W-1:0]         last_idx;

	logic                              mem_re;
	logic [ims_pkg::IDX_W-1:0]         raddr;
	logic                              mem_we;
	logic [ims_pkg::IDX_W-1:0]         waddr;
	logic [ims_pkg::VALUE_W-1:0]       wdata;
	logic                              cnt_inc;
	logic                              cnt_dec;
	logic                              out_load;

	assign hit      = cmp_vld_q && (rdata_q == value_q);
	assign miss     = (issue_idx_q == cnt_q) && !cmp_vld_q;
	assign out_free = !out_vld_q || pop;
	assign can_add  = (cnt_q < ims_pkg::CNT_W'(ims_pkg::CAPACITY));
	assign last_idx = cnt_q - 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ims_pkg::ENG_IDLE: begin
				if (lnk.vld) state_d = ims_pkg::ENG_SCAN;
			end
			ims_pkg::ENG_SCAN: begin
				if (hit || miss) state_d = ims_pkg::ENG_ACT;
			end
			ims_pkg::ENG_ACT: begin
				if (op_q == ims_pkg::OP_REMOVE && found_q) state_d = ims_pkg::ENG_READ_LAST;
				else state_d = ims_pkg::ENG_EMIT;
			end
			ims_pkg::ENG_READ_LAST:  state_d = ims_pkg::ENG_WRITE_LAST;
			ims_pkg::ENG_WRITE_LAST: state_d = ims_pkg::ENG_EMIT;
			ims_pkg::ENG_EMIT: begin
				if (out_free) state_d = ims_pkg::ENG_IDLE;
			end
			default: state_d = ims_pkg::ENG_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		take     = 1'b0;
		mem_re   = 1'b0;
		raddr    = issue_idx_q[ims_pkg::IDX_W-1:0];
		mem_we   = 1'b0;
		waddr    = cnt_q[ims_pkg::IDX_W-1:0];
		wdata    = value_q;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ims_pkg::ENG_IDLE: begin
				take = lnk.vld;
			end
			ims_pkg::ENG_SCAN: begin
				mem_re = (issue_idx_q < cnt_q) && !hit;
			end
			ims_pkg::ENG_ACT: begin
				if (op_q == ims_pkg::OP_INSERT && !found_q && can_add) begin
					mem_we  = 1'b1;
					cnt_inc = 1'b1;
				end
			end
			ims_pkg::ENG_READ_LAST: begin
				mem_re = 1'b1;
				raddr  = last_idx[ims_pkg::IDX_W-1:0];
			end
			ims_pkg::ENG_WRITE_LAST: begin
				mem_we  = 1'b1;
				waddr   = slot_q;
				wdata   = rdata_q;
				cnt_dec = 1'b1;
			end
			ims_pkg::ENG_EMIT: begin
				out_load = out_free;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	// entry table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	// datapath without reset
	always_ff @(posedge clk) begin
		if (take) begin
			op_q    <= lnk.cmd.op;
			value_q <= lnk.cmd.value;
		end
		if (mem_re) begin
			cmp_idx_q <= raddr;
		end
		if (state_q == ims_pkg::ENG_SCAN && (hit || miss)) begin
			found_q   <= hit;
			slot_q    <= cmp_idx_q;
			refused_q <= (op_q == ims_pkg::OP_INSERT) && !hit && !can_add;
		end
		if (out_load) begin
			out_q.was_present <= found_q;
			out_q.status      <= refused_q;
			out_q.count       <= ims_pkg::to_count_field(cnt_q);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ims_pkg::ENG_IDLE;
			cnt_q       <= '0;
			issue_idx_q <= '0;
			cmp_vld_q   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			cmp_vld_q <= mem_re && (state_q == ims_pkg::ENG_SCAN);
			if (take) begin
				issue_idx_q <= '0;
			end else if (mem_re && state_q == ims_pkg::ENG_SCAN) begin
				issue_idx_q <= issue_idx_q + 1'b1;
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign empty  = !out_vld_q;
	assign result = out_q;

endmodule

>>> design/integer_membership_set.sv
// ----------------------------------------------------------------------------
// integer_membership_set
// set of distinct 32-bit values in an unsorted table with swap removal
//
//   channel  | dir | handshake             | beat
//   ---------+-----+-----------------------+---------------------------------
//   item     | in  | push, full            | mode, value
//   result   | out | empty, pop            | was_present, status, count
//
// one item at a time is searched over the live entries through the table's
// single read port; a hit ends the search early, and a removal of a found
// value then reads the last entry and writes it into the freed slot.
// a two-entry command queue takes beats while the engine searches, and a
// result register holds one finished beat while the next item runs.
// asynchronous reset empties the set; table contents need no clearing.
// ----------------------------------------------------------------------------
module integer_membership_set (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  ims_pkg::in_item_t   item,
	output logic                empty,
	input  logic                pop,
	output ims_pkg::out_item_t  result
);

	ims_pkg::cmd_lnk_t lnk;
	logic              take;

	ims_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.lnk    (lnk),
		.take   (take)
	);

	ims_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.lnk    (lnk),
		.take   (take),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

>>> design/ims_checker.sv
// ----------------------------------------------------------------------------
// ims_checker
// port-level checks of the integer membership set, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ims_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input ims_pkg::in_item_t   item,
	input logic                empty,
	input logic                pop,
	input ims_pkg::out_item_t  result
);

	logic [ims_pkg::COUNT_W-1:0] prev_cnt_q;
	logic                        prev_vld_q;
	logic                        step_ok;

	// count of the last delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cnt_q <= '0;
			prev_vld_q <= 1'b0;
		end else if (pop && !empty) begin
			prev_cnt_q <= result.count;
			prev_vld_q <= 1'b1;
		end
	end

	assign step_ok = (result.count == prev_cnt_q)
		|| (result.count == prev_cnt_q + 1'b1)
		|| (result.count == prev_cnt_q - 1'b1);

	`IMS_ASSERT_NEXT(a_result_held, clk, arst_n, !empty && !pop, !empty && $stable(result))
	`IMS_ASSERT_IMPLY(a_refused_absent, clk, arst_n, !empty && result.status, !result.was_present)
	`IMS_ASSERT_IMPLY(a_refused_full, clk, arst_n, !empty && result.status, result.count == ims_pkg::to_count_field(ims_pkg::CNT_W'(ims_pkg::CAPACITY)))
	`IMS_ASSERT_IMPLY(a_count_step, clk, arst_n, !empty && prev_vld_q, step_ok)

endmodule

bind integer_membership_set ims_checker u_ims_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.item   (item),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
